FILE: sv/pfe_pkg.sv
// Shared constants, codes and types of the postfix expression evaluator.
package pfe_pkg;

	localparam int WORD_W              = 32;
	localparam int SYMBOL_W            = 8;
	localparam int OPERAND_W           = 9;
	localparam int DEFAULT_STACK_DEPTH = 16;
	localparam int QUEUE_DEPTH         = 4;

	localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'd45;
	localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'd42;
	localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'd47;

	localparam logic [WORD_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

	typedef logic [1:0] err_t;
	localparam err_t ERR_NONE      = 2'd0;
	localparam err_t ERR_UNDERFLOW = 2'd1;
	localparam err_t ERR_OVERFLOW  = 2'd2;
	localparam err_t ERR_DIVZERO   = 2'd3;

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_PUSH = 3'd0;
	localparam kind_t KIND_ADD  = 3'd1;
	localparam kind_t KIND_SUB  = 3'd2;
	localparam kind_t KIND_MUL  = 3'd3;
	localparam kind_t KIND_DIV  = 3'd4;

	// One classified character as it travels from the front to the back.
	typedef struct packed {
		kind_t                        kind;
		logic signed [OPERAND_W-1:0]  operand;
		logic                         last;
	} word_t;

endpackage

FILE: sv/pfe_if.sv
// Channel interfaces: expression characters in, evaluation results out.
interface pfe_expr_if import pfe_pkg::*;;
	logic                valid;
	logic                ready;
	logic [SYMBOL_W-1:0] symbol;
	logic                last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

interface pfe_result_if import pfe_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [WORD_W-1:0]  value;
	err_t                      error;

	modport source (output valid, output value, output error, input ready);
	modport sink (input valid, input value, input error, output ready);
endinterface

FILE: sv/pfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/pfe_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pfe_div import pfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] num,
	input  logic [WORD_W-1:0] den,
	output logic              done,
	output logic [WORD_W-1:0] quot
);

	localparam int CNT_W = $clog2(WORD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] den_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;

	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Work on magnitudes; fix the sign at the end.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[WORD_W-1] ^ den[WORD_W-1];
			rem_q <= '0;
			quo_q <= num[WORD_W-1] ? (WORD_W'(0) - num) : num;
			den_q <= den[WORD_W-1] ? (WORD_W'(0) - den) : den;
		end else if (busy_q) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? (WORD_W'(0) - quo_q) : quo_q;

endmodule

FILE: sv/pfe_front.sv
// Front end: accept characters, classify them, hold one word for the queue.
module pfe_front import pfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pfe_expr_if.sink   expr,
	output logic       word_valid,
	output word_t      word,
	input  logic       word_ready
);

	logic  hold_valid_q;
	word_t hold_q;
	word_t classified;

	always_comb begin
		classified.last    = expr.last;
		classified.operand = signed'({1'b0, expr.symbol}) - signed'({1'b0, CH_ZERO});
		case (expr.symbol)
			CH_PLUS:  classified.kind = KIND_ADD;
			CH_MINUS: classified.kind = KIND_SUB;
			CH_STAR:  classified.kind = KIND_MUL;
			CH_SLASH: classified.kind = KIND_DIV;
			default:  classified.kind = KIND_PUSH;
		endcase
	end

	assign expr.ready = !hold_valid_q || word_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (expr.ready) begin
			hold_valid_q <= expr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (expr.valid && expr.ready) begin
			hold_q <= classified;
		end
	end

	assign word_valid = hold_valid_q;
	assign word       = hold_q;

endmodule

FILE: sv/pfe_fifo.sv
// Short queue of classified words between the front and the back.
module pfe_fifo import pfe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  word_t push_word,
	output logic  push_ready,
	output logic  pop_valid,
	output word_t pop_word,
	input  logic  pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	word_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_word   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

FILE: sv/pfe_back.sv
// Back end: operand stack, arithmetic sequencer and result register.
module pfe_back import pfe_pkg::*; #(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         word_valid,
	input  word_t        word,
	output logic         word_pop,
	pfe_result_if.source result
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CALC = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;

	logic [2:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [WORD_W-1:0] top_q;
	err_t              err_q;
	kind_t             kind_q;
	logic              last_q;
	logic [WORD_W-1:0] right_q;
	logic              left_ok_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_value_q;
	err_t              out_error_q;

	logic              ram_we;
	logic              ram_re;
	logic [CW-1:0]     below_top;
	logic [CW-1:0]     second;
	logic [WORD_W-1:0] ram_rdata;
	logic [WORD_W-1:0] left;
	logic [WORD_W-1:0] pushed;
	logic              div_start;
	logic              div_done;
	logic [WORD_W-1:0] div_quot;
	logic              out_free;

	// The top of the stack lives in top_q; the RAM holds the entries below it.
	assign below_top = count_q - CW'(1);
	assign second    = count_q - CW'(2);
	assign word_pop  = (state_q == ST_IDLE) && word_valid;
	assign ram_we    = word_pop && (word.kind == KIND_PUSH) && (count_q != '0)
		&& (count_q < CW'(STACK_DEPTH));
	assign ram_re    = word_pop && (word.kind != KIND_PUSH) && (count_q >= CW'(2));
	assign left      = left_ok_q ? ram_rdata : EMPTY_VALUE;
	assign pushed    = {{(WORD_W - OPERAND_W){word.operand[OPERAND_W-1]}}, word.operand};
	assign div_start = (state_q == ST_CALC) && (kind_q == KIND_DIV) && (right_q != '0);
	assign out_free  = !out_valid_q || result.ready;

	pfe_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (below_top[AW-1:0]),
		.wdata (top_q),
		.re    (ram_re),
		.raddr (second[AW-1:0]),
		.rdata (ram_rdata)
	);

	pfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (left),
		.den    (right_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (word_valid) begin
						if (word.kind == KIND_PUSH) begin
							if (count_q >= CW'(STACK_DEPTH)) begin
								if (err_q == ERR_NONE) begin
									err_q <= ERR_OVERFLOW;
								end
							end else begin
								count_q <= count_q + CW'(1);
							end
							state_q <= word.last ? ST_EMIT : ST_IDLE;
						end else begin
							if (count_q < CW'(2)) begin
								if (err_q == ERR_NONE) begin
									err_q <= ERR_UNDERFLOW;
								end
								count_q <= '0;
							end else begin
								count_q <= second;
							end
							state_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					if (kind_q == KIND_DIV && right_q != '0) begin
						state_q <= ST_DIV;
					end else begin
						if (kind_q == KIND_DIV && err_q == ERR_NONE) begin
							err_q <= ERR_DIVZERO;
						end
						count_q <= count_q + CW'(1);
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						count_q <= '0;
						err_q   <= ERR_NONE;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (word_valid) begin
					kind_q <= word.kind;
					last_q <= word.last;
					if (word.kind == KIND_PUSH) begin
						if (count_q < CW'(STACK_DEPTH)) begin
							top_q <= pushed;
						end
					end else begin
						right_q   <= (count_q != '0) ? top_q : EMPTY_VALUE;
						left_ok_q <= (count_q >= CW'(2));
					end
				end
			end
			ST_CALC: begin
				case (kind_q)
					KIND_ADD: top_q <= left + right_q;
					KIND_SUB: top_q <= left - right_q;
					KIND_MUL: top_q <= left * right_q;
					default:  top_q <= '0;
				endcase
			end
			ST_DIV: begin
				if (div_done) begin
					top_q <= div_quot;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_value_q <= (count_q != '0) ? top_q : EMPTY_VALUE;
					out_error_q <= err_q;
				end
			end
			default: begin
				top_q <= top_q;
			end
		endcase
	end

	assign result.valid = out_valid_q;
	assign result.value = signed'(out_value_q);
	assign result.error = out_error_q;

endmodule

FILE: sv/postfix_expression_evaluator_top.sv
// A final digit's result goes valid after the front register, the queue and the back end.
// Sequencing: the back end runs one word at a time: an operand takes the idle state, + - *
// take idle and calc, / also div unless the divisor is zero; a result then takes emit.
// The front register and a 4-word queue keep accepting while the back end is busy.
// Reset (arst_n low, asynchronous): stack empty, error cleared, queue empty, no result.
// Stack RAM contents are not cleared; only entries pushed since are ever read.
module postfix_expression_evaluator_top import pfe_pkg::*; #(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	pfe_expr_if.sink     expr,
	pfe_result_if.source result
);

	// Front to queue
	logic  front_valid;
	word_t front_word;
	logic  front_ready;

	// Queue to back
	logic  queue_valid;
	word_t queue_word;
	logic  queue_pop;

	// Classify each character into an operation kind and a 9-bit signed operand.
	pfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.expr       (expr),
		.word_valid (front_valid),
		.word       (front_word),
		.word_ready (front_ready)
	);

	// Buffer words so a long divide does not stall the input side at once.
	pfe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_word  (front_word),
		.push_ready (front_ready),
		.pop_valid  (queue_valid),
		.pop_word   (queue_word),
		.pop        (queue_pop)
	);

	// Evaluate: stack push and pop, arithmetic, sticky error, result register.
	pfe_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (queue_valid),
		.word       (queue_word),
		.word_pop   (queue_pop),
		.result     (result)
	);

endmodule

FILE: sv/pfe_checker.sv
// Port-level checks of the evaluator, bound to the top level.
module pfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_value,
	input logic [1:0]  out_error
);

	// Expressions whose final character is in but whose result is not yet taken.
	logic [3:0] pending_q;
	logic       last_in;
	logic       res_out;

	assign last_in = in_valid && in_ready && in_last;
	assign res_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !res_out) begin
			pending_q <= pending_q + 4'd1;
		end else if (res_out && !last_in) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_error))
		else $error("result changed while stalled");

	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("result without a final character");

	a_pending_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd7)
		else $error("more expressions in flight than the buffers hold");

	a_no_result_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result shown right after reset");

endmodule

bind postfix_expression_evaluator_top pfe_checker u_pfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (expr.valid),
	.in_ready  (expr.ready),
	.in_last   (expr.last),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_value (result.value),
	.out_error (result.error)
);

FILE: verif/postfix_expression_evaluator_top_tb.sv
// Self-checking testbench of the postfix expression evaluator: directed and random expressions.
module postfix_expression_evaluator_top_tb;
	import pfe_pkg::*;

	// Total words to send before closing the run; the random part stops here.
	localparam int unsigned WORD_TARGET  = 1300;
	// Receiver hold-off, long enough to fill the front register and the queue.
	localparam int unsigned HOLD_CYCLES  = 300;
	// Settle time after the last result, well past the path through the block and one divide.
	localparam int unsigned DRAIN_CYCLES = 80;
	// Random idle chance on either side, in percent.
	localparam int unsigned IDLE_PCT     = 22;

	// One evaluation result: top of stack and first error of the expression.
	typedef struct {
		logic [WORD_W-1:0] value;
		err_t              error;
	} eval_result_t;

	// Evaluation predictor plus the store of results still owed by the block.
	class pfe_scoreboard;
		logic [WORD_W-1:0] operands[DEFAULT_STACK_DEPTH];
		int unsigned       operand_count;
		err_t              first_error;
		eval_result_t      owed_results[$];
		int unsigned       mismatches;

		function new();
			operand_count = 0;
			first_error   = ERR_NONE;
			mismatches    = 0;
		endfunction

		// Keep only the first error since the last result.
		function void flag_error(err_t code);
			if (first_error == ERR_NONE) begin
				first_error = code;
			end
		endfunction

		// Drop the word and flag overflow when the stack is full.
		function void push_operand(logic [WORD_W-1:0] v);
			if (operand_count >= DEFAULT_STACK_DEPTH) begin
				flag_error(ERR_OVERFLOW);
			end else begin
				operands[operand_count] = v;
				operand_count++;
			end
		endfunction

		// An empty stack yields all ones and flags underflow.
		function logic [WORD_W-1:0] pop_operand();
			if (operand_count == 0) begin
				flag_error(ERR_UNDERFLOW);
				return EMPTY_VALUE;
			end
			operand_count--;
			return operands[operand_count];
		endfunction

		// Signed quotient truncated toward zero, worked out on magnitudes.
		function logic [WORD_W-1:0] signed_quotient(logic [WORD_W-1:0] num,
				logic [WORD_W-1:0] den);
			logic              num_neg;
			logic              den_neg;
			logic [WORD_W-1:0] num_mag;
			logic [WORD_W-1:0] den_mag;
			logic [WORD_W-1:0] quo;
			num_neg = num[WORD_W-1];
			den_neg = den[WORD_W-1];
			num_mag = num_neg ? -num : num;
			den_mag = den_neg ? -den : den;
			if (den_mag == '0) begin
				flag_error(ERR_DIVZERO);
				return '0;
			end
			quo = num_mag / den_mag;
			return (num_neg != den_neg) ? -quo : quo;
		endfunction

		// Advance the predicted stack by one accepted word; owe a result on last.
		function void note_word(logic [SYMBOL_W-1:0] symbol, logic last);
			logic [WORD_W-1:0] rhs;
			logic [WORD_W-1:0] lhs;
			eval_result_t      owed;
			if (symbol == CH_PLUS || symbol == CH_MINUS || symbol == CH_STAR ||
					symbol == CH_SLASH) begin
				rhs = pop_operand();
				lhs = pop_operand();
				case (symbol)
					CH_PLUS:  push_operand(lhs + rhs);
					CH_MINUS: push_operand(lhs - rhs);
					CH_STAR:  push_operand(lhs * rhs);
					default:  push_operand(signed_quotient(lhs, rhs));
				endcase
			end else begin
				push_operand({{(WORD_W-SYMBOL_W){1'b0}}, symbol} -
					{{(WORD_W-SYMBOL_W){1'b0}}, CH_ZERO});
			end
			if (last) begin
				owed.value = (operand_count != 0) ? operands[operand_count - 1] : EMPTY_VALUE;
				owed.error = first_error;
				owed_results.push_back(owed);
				operand_count = 0;
				first_error   = ERR_NONE;
			end
		endfunction

		task report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
			mismatches++;
			$display("MISMATCH %s: got %08h, want %08h at %0t", what, got, want, $time);
		endtask

		// Compare one accepted result with the oldest owed one, field by field.
		task check_result(logic [WORD_W-1:0] value, err_t error);
			eval_result_t want;
			if (owed_results.size() == 0) begin
				report_mismatch("result with nothing owed", value, '0);
				return;
			end
			want = owed_results.pop_front();
			if (value !== want.value) begin
				report_mismatch("value", value, want.value);
			end
			if (error !== want.error) begin
				report_mismatch("error", {{(WORD_W-2){1'b0}}, error},
					{{(WORD_W-2){1'b0}}, want.error});
			end
		endtask

		function int unsigned pending();
			return owed_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pfe_expr_if   expr_ch ();
	pfe_result_if result_ch ();

	pfe_scoreboard sb = new();

	// Random idling on both sides; cleared for a stretch with no gaps at all.
	bit          idle_enabled = 1'b1;
	// Raised once by the stimulus to ask the receiver for its long hold-off.
	bit          hold_request = 1'b0;
	int unsigned words_sent   = 0;
	logic        last_was_end = 1'b1;

	postfix_expression_evaluator_top #(
		.STACK_DEPTH(DEFAULT_STACK_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.expr  (expr_ch),
		.result(result_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one word, idling at random first; return at the edge that accepts it.
	task automatic send_word(input logic [SYMBOL_W-1:0] symbol, input logic last);
		while (idle_enabled && $urandom_range(99) < IDLE_PCT) begin
			expr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		expr_ch.valid  <= 1'b1;
		expr_ch.symbol <= symbol;
		expr_ch.last   <= last;
		@(posedge clk);
		while (!expr_ch.ready) begin
			@(posedge clk);
		end
		sb.note_word(symbol, last);
		words_sent++;
		last_was_end = last;
	endtask

	// Mostly decimal digits, now and then any byte that is not an operator.
	function automatic logic [SYMBOL_W-1:0] pick_operand();
		logic [SYMBOL_W-1:0] sym;
		if ($urandom_range(99) < 80) begin
			return CH_ZERO + SYMBOL_W'($urandom_range(9));
		end
		do begin
			sym = SYMBOL_W'($urandom_range(255));
		end while (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH);
		return sym;
	endfunction

	function automatic logic [SYMBOL_W-1:0] pick_operator();
		case ($urandom_range(3))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// Send one well-formed expression with random content; mostly short ones.
	task automatic send_expression();
		int unsigned span;
		int unsigned depth;
		int unsigned emitted;
		logic        finished;
		logic [SYMBOL_W-1:0] sym;
		span     = ($urandom_range(9) == 0) ? $urandom_range(31, 13) : $urandom_range(12, 1);
		depth    = 0;
		emitted  = 0;
		finished = 1'b0;
		while (!finished) begin
			// Reduce once the span is used up or the stack is full; else pick freely.
			if (depth >= 2 && (emitted >= span || depth >= DEFAULT_STACK_DEPTH ||
					$urandom_range(1) == 1)) begin
				sym = pick_operator();
				depth--;
			end else begin
				sym = pick_operand();
				depth++;
			end
			emitted++;
			finished = (emitted >= span) && (depth <= 1);
			send_word(sym, finished);
		end
	endtask

	// Send a short run of arbitrary bytes with arbitrary end marks.
	task automatic send_noise();
		int unsigned count;
		count = $urandom_range(6, 1);
		repeat (count) begin
			send_word(SYMBOL_W'($urandom_range(255)), $urandom_range(3) == 0);
		end
	endtask

	// Result side: check every accepted word, then pick ready for the next edge.
	int unsigned hold_left  = 0;
	bit          hold_taken = 1'b0;

	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			sb.check_result(result_ch.value, result_ch.error);
		end
		if (hold_request && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= !(idle_enabled && $urandom_range(99) < IDLE_PCT);
		end
	end

	initial begin
		arst_n         <= 1'b0;
		expr_ch.valid  <= 1'b0;
		expr_ch.symbol <= '0;
		expr_ch.last   <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Underflow: an operator on an empty stack adds two all-ones words.
		send_word(CH_PLUS, 1'b1);

		// Divide by zero: the quotient reads zero.
		send_word(CH_ZERO + 8'd3, 1'b0);
		send_word(CH_ZERO, 1'b0);
		send_word(CH_SLASH, 1'b1);

		// Most negative value divided by minus one: build 2^31, then 0 - 1, then divide.
		send_word(CH_ZERO + 8'd128, 1'b0);
		send_word(CH_ZERO + 8'd128, 1'b0);
		send_word(CH_STAR, 1'b0);
		send_word(CH_ZERO + 8'd128, 1'b0);
		send_word(CH_STAR, 1'b0);
		send_word(CH_ZERO + 8'd128, 1'b0);
		send_word(CH_STAR, 1'b0);
		send_word(CH_ZERO + 8'd8, 1'b0);
		send_word(CH_STAR, 1'b0);
		send_word(CH_ZERO, 1'b0);
		send_word(CH_ZERO + 8'd1, 1'b0);
		send_word(CH_MINUS, 1'b0);
		send_word(CH_SLASH, 1'b1);

		// Overflow: fill the stack starting with both symbol extremes, push one more,
		// then add the two top words.
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		repeat (DEFAULT_STACK_DEPTH - 2) send_word(CH_ZERO + 8'd1, 1'b0);
		send_word(CH_ZERO + 8'd2, 1'b0);
		send_word(CH_PLUS, 1'b1);

		// Random part: ask for the long hold-off right away so the block backs up.
		hold_request = 1'b1;
		while (words_sent < WORD_TARGET) begin
			idle_enabled = !(words_sent >= 500 && words_sent < 800);
			if ($urandom_range(99) < 12) begin
				send_noise();
			end else begin
				send_expression();
			end
		end
		idle_enabled = 1'b1;
		// Close any open expression so every accepted word is accounted for.
		if (!last_was_end) begin
			send_word(CH_ZERO + 8'd7, 1'b1);
		end
		expr_ch.valid <= 1'b0;

		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Hard stop: many times the slowest correct run (all divides, all stalls).
	initial begin
		#(4 * 600_000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
